@@ rtl/tunable_white_dimmer_control_defines.svh @@
// assertion macros used by the dimmer control top file
`ifndef TUNABLE_WHITE_DIMMER_CONTROL_DEFINES_SVH
`define TUNABLE_WHITE_DIMMER_CONTROL_DEFINES_SVH

// antecedent and consequent checked in the same cycle
`define TWDC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define TWDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/twdc_pkg.sv @@
`timescale 1ns / 1ps

package twdc_pkg;

   // number of buttons that carry a gesture mapping
   localparam int BUTTONS = 4;

   // mix preset thresholds and middle preset
   localparam logic [9:0] MIX_LOW_EDGE  = 10'd341;
   localparam logic [9:0] MIX_HIGH_EDGE = 10'd682;
   localparam logic [9:0] MIX_PRESET    = 10'd512;

   // item action codes
   typedef enum logic [2:0] {
      ACT_CLICK     = 3'd0,
      ACT_HOLD      = 3'd1,
      ACT_RELEASE   = 3'd2,
      ACT_SET_ON    = 3'd3,
      ACT_SET_LEVEL = 3'd4,
      ACT_SET_MIX   = 3'd5,
      ACT_TOGGLE    = 3'd6
   } action_type;

   // per-button action kinds
   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_TOGGLE = 3'd1,
      KIND_LEVEL  = 3'd2,
      KIND_MIX    = 3'd3,
      KIND_COLD   = 3'd4,
      KIND_WARM   = 3'd5
   } kind_type;

   // duty modes (code 3 behaves as the colour mix mode)
   typedef enum logic [1:0] {
      MODE_SINGLE = 2'd0,
      MODE_DUAL   = 2'd1,
      MODE_MIX    = 2'd2
   } mode_type;

   // register indexes on the csr port
   typedef enum logic [3:0] {
      CSR_MODE       = 4'd0,
      CSR_LEVEL_MIN  = 4'd1,
      CSR_LEVEL_MAX  = 4'd2,
      CSR_COLD_RANGE = 4'd3,
      CSR_WARM_RANGE = 4'd4,
      CSR_LEVEL_STEP = 4'd5,
      CSR_MIX_STEP   = 4'd6,
      CSR_BUTTON_MAP = 4'd7
   } csr_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MIX_COLD,
      ST_MIX_WARM,
      ST_COLD_MUL,
      ST_COLD_DIV,
      ST_WARM_MUL,
      ST_WARM_DIV,
      ST_DONE
   } state_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic apply;
      logic prep;
      logic mix_cold;
      logic mix_warm;
      logic span_mul;
      logic span_div;
      logic warm;
      logic load_out;
   } cmd_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic composite;
   } status_type;

endpackage

@@ rtl/twdc_ctrl.sv @@
`timescale 1ns / 1ps

module twdc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  twdc_pkg::status_type   status,
   output twdc_pkg::cmd_type      cmd
);

   twdc_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // state and result flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= twdc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         twdc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.apply = 1'b1;
               state_in  = twdc_pkg::ST_PREP;
            end
         end
         twdc_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.composite ? twdc_pkg::ST_MIX_COLD : twdc_pkg::ST_COLD_MUL;
         end
         twdc_pkg::ST_MIX_COLD: begin
            cmd.mix_cold = 1'b1;
            state_in     = twdc_pkg::ST_MIX_WARM;
         end
         twdc_pkg::ST_MIX_WARM: begin
            cmd.mix_warm = 1'b1;
            state_in     = twdc_pkg::ST_COLD_MUL;
         end
         twdc_pkg::ST_COLD_MUL: begin
            cmd.span_mul = 1'b1;
            state_in     = twdc_pkg::ST_COLD_DIV;
         end
         twdc_pkg::ST_COLD_DIV: begin
            cmd.span_div = 1'b1;
            state_in     = twdc_pkg::ST_WARM_MUL;
         end
         twdc_pkg::ST_WARM_MUL: begin
            cmd.span_mul = 1'b1;
            cmd.warm     = 1'b1;
            state_in     = twdc_pkg::ST_WARM_DIV;
         end
         twdc_pkg::ST_WARM_DIV: begin
            cmd.span_div = 1'b1;
            cmd.warm     = 1'b1;
            state_in     = twdc_pkg::ST_DONE;
         end
         twdc_pkg::ST_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = twdc_pkg::ST_IDLE;
            end
         end
         default: state_in = twdc_pkg::ST_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/twdc_datapath.sv @@
`timescale 1ns / 1ps

module twdc_datapath #(
   parameter int DUTY_FULL = 1023
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [3:0]           csr_index,
   input  logic [19:0]          csr_data,
   input  logic [2:0]           req_action,
   input  logic [1:0]           req_button,
   input  logic [15:0]          req_value,
   input  twdc_pkg::cmd_type    cmd,
   output twdc_pkg::status_type status,
   output logic [9:0]           rsp_cold_duty,
   output logic [9:0]           rsp_warm_duty,
   output logic                 rsp_is_on,
   output logic [9:0]           rsp_level_now,
   output logic [9:0]           rsp_mix_now
);

   // widths of the divide by full scale done as a reciprocal multiply
   localparam int DW    = $clog2(DUTY_FULL + 1);
   localparam int DIVW  = $clog2((1 << 20) + DUTY_FULL);
   localparam int SHIFT = DIVW + DW + 1;
   localparam int RW    = SHIFT - DW + 2;
   localparam int QW    = DIVW - DW + 2;
   localparam int PW    = DIVW + RW;
   localparam int SW    = ((QW > 10) ? QW : 10) + 1;
   localparam logic [RW-1:0] RECIP =
      RW'(((64'd1 << SHIFT) + 64'(DUTY_FULL) - 64'd1) / 64'(DUTY_FULL));
   localparam logic [9:0] LEVEL_TOP  = 10'((DUTY_FULL < 1023) ? DUTY_FULL : 1023);
   localparam logic [9:0] PRESET_MID =
      (twdc_pkg::MIX_PRESET < LEVEL_TOP) ? twdc_pkg::MIX_PRESET : LEVEL_TOP;

   // direction flag slots
   localparam int DIR_LEVEL = 0;
   localparam int DIR_MIX   = 1;
   localparam int DIR_COLD  = 2;
   localparam int DIR_WARM  = 3;

   // configuration registers
   logic [1:0]  mode_ff, mode_in;
   logic [9:0]  lvl_min_ff, lvl_min_in, lvl_max_ff, lvl_max_in;
   logic [19:0] cold_rng_ff, cold_rng_in, warm_rng_ff, warm_rng_in;
   logic [9:0]  lvl_step_ff, lvl_step_in, mix_step_ff, mix_step_in;
   logic [11:0] btn_map_ff, btn_map_in;

   // dimmer state
   logic        on_ff, on_in;
   logic [9:0]  level_ff, level_in, mix_ff, mix_in;
   logic [9:0]  cold_lvl_ff, cold_lvl_in, warm_lvl_ff, warm_lvl_in;
   logic [3:0]  dir_ff, dir_in;

   // per-item working registers
   logic [9:0]      b_ff, b_in, vc_ff, vc_in, vw_ff, vw_in;
   logic [DIVW-1:0] prod_ff, prod_in;
   logic [9:0]      cold_ff, cold_in, warm_ff, warm_in;
   logic [9:0]      out_cold_ff, out_cold_in, out_warm_ff, out_warm_in;
   logic            out_on_ff, out_on_in;
   logic [9:0]      out_level_ff, out_level_in, out_mix_ff, out_mix_in;

   logic [2:0]          kind_code;
   twdc_pkg::kind_type  kind;
   logic [9:0]          b_now, m_now, sat_value;
   logic [9:0]          mul_a, mul_b;
   logic [19:0]         mul_p;
   logic [PW-1:0]       div_p;
   logic [QW-1:0]       div_q;
   logic [19:0]         rng;
   logic [9:0]          rng_lo, rng_hi, span_v, span_res;
   logic [SW-1:0]       span_sum;
   logic                is_single, is_dual;

   function automatic logic [9:0] bound(input logic [9:0] v, input logic [9:0] lo,
                                        input logic [9:0] hi);
      if (v < lo) begin
         bound = lo;
      end else if (v > hi) begin
         bound = hi;
      end else begin
         bound = v;
      end
   endfunction

   function automatic logic [9:0] move_level(input logic [9:0] v, input logic up,
                                             input logic [9:0] step, input logic [9:0] lo,
                                             input logic [9:0] hi);
      logic [9:0]  s;
      logic [10:0] lo_sum;
      s      = (step < hi) ? step : hi;
      lo_sum = {1'b0, lo} + {1'b0, step};
      if (up) begin
         move_level = (v >= hi - s) ? hi : v + step;
      end else begin
         move_level = ({1'b0, v} <= lo_sum) ? lo : v - step;
      end
   endfunction

   function automatic logic [9:0] move_mix(input logic [9:0] v, input logic up,
                                           input logic [9:0] step);
      if (up) begin
         move_mix = (step >= LEVEL_TOP || v >= LEVEL_TOP - step) ? LEVEL_TOP : v + step;
      end else begin
         move_mix = (v <= step) ? 10'd0 : v - step;
      end
   endfunction

   // button to action kind, unmapped codes act as none
   always_comb begin
      kind = twdc_pkg::KIND_NONE;
      case (req_button)
         2'd0:    kind_code = btn_map_ff[2:0];
         2'd1:    kind_code = btn_map_ff[5:3];
         2'd2:    kind_code = btn_map_ff[8:6];
         default: kind_code = btn_map_ff[11:9];
      endcase
      if (int'(req_button) < twdc_pkg::BUTTONS && kind_code <= twdc_pkg::KIND_WARM) begin
         kind = twdc_pkg::kind_type'(kind_code);
      end
   end

   assign sat_value = (req_value > 16'(LEVEL_TOP)) ? LEVEL_TOP : req_value[9:0];

   // configuration writes
   always_comb begin
      mode_in     = mode_ff;
      lvl_min_in  = lvl_min_ff;
      lvl_max_in  = lvl_max_ff;
      cold_rng_in = cold_rng_ff;
      warm_rng_in = warm_rng_ff;
      lvl_step_in = lvl_step_ff;
      mix_step_in = mix_step_ff;
      btn_map_in  = btn_map_ff;
      if (csr_we) begin
         unique case (csr_index)
            twdc_pkg::CSR_MODE:       mode_in     = csr_data[1:0];
            twdc_pkg::CSR_LEVEL_MIN:  lvl_min_in  = csr_data[9:0];
            twdc_pkg::CSR_LEVEL_MAX:  lvl_max_in  = csr_data[9:0];
            twdc_pkg::CSR_COLD_RANGE: cold_rng_in = csr_data;
            twdc_pkg::CSR_WARM_RANGE: warm_rng_in = csr_data;
            twdc_pkg::CSR_LEVEL_STEP: lvl_step_in = csr_data[9:0];
            twdc_pkg::CSR_MIX_STEP:   mix_step_in = csr_data[9:0];
            twdc_pkg::CSR_BUTTON_MAP: btn_map_in  = csr_data[11:0];
            default: ;
         endcase
      end
   end

   // state update for an accepted item
   always_comb begin
      on_in       = on_ff;
      level_in    = level_ff;
      mix_in      = mix_ff;
      cold_lvl_in = cold_lvl_ff;
      warm_lvl_in = warm_lvl_ff;
      dir_in      = dir_ff;
      if (cmd.apply) begin
         unique case (req_action)
            twdc_pkg::ACT_CLICK: begin
               case (kind) inside
                  twdc_pkg::KIND_TOGGLE, twdc_pkg::KIND_LEVEL: on_in = ~on_ff;
                  twdc_pkg::KIND_MIX: begin
                     on_in = 1'b1;
                     if (mix_ff < twdc_pkg::MIX_LOW_EDGE) begin
                        mix_in = PRESET_MID;
                     end else if (mix_ff < twdc_pkg::MIX_HIGH_EDGE) begin
                        mix_in = LEVEL_TOP;
                     end else begin
                        mix_in = 10'd0;
                     end
                  end
                  default: ;
               endcase
            end
            twdc_pkg::ACT_HOLD: begin
               case (kind)
                  twdc_pkg::KIND_LEVEL: begin
                     on_in    = 1'b1;
                     level_in = move_level(level_ff, dir_ff[DIR_LEVEL], lvl_step_ff,
                                           lvl_min_ff, lvl_max_ff);
                  end
                  twdc_pkg::KIND_MIX: begin
                     on_in  = 1'b1;
                     mix_in = move_mix(mix_ff, dir_ff[DIR_MIX], mix_step_ff);
                  end
                  twdc_pkg::KIND_COLD: begin
                     on_in       = 1'b1;
                     cold_lvl_in = move_level(cold_lvl_ff, dir_ff[DIR_COLD], lvl_step_ff,
                                              lvl_min_ff, lvl_max_ff);
                  end
                  twdc_pkg::KIND_WARM: begin
                     on_in       = 1'b1;
                     warm_lvl_in = move_level(warm_lvl_ff, dir_ff[DIR_WARM], lvl_step_ff,
                                              lvl_min_ff, lvl_max_ff);
                  end
                  default: ;
               endcase
            end
            twdc_pkg::ACT_RELEASE: begin
               case (kind)
                  twdc_pkg::KIND_LEVEL: dir_in[DIR_LEVEL] = ~dir_ff[DIR_LEVEL];
                  twdc_pkg::KIND_MIX:   dir_in[DIR_MIX]   = ~dir_ff[DIR_MIX];
                  twdc_pkg::KIND_COLD:  dir_in[DIR_COLD]  = ~dir_ff[DIR_COLD];
                  twdc_pkg::KIND_WARM:  dir_in[DIR_WARM]  = ~dir_ff[DIR_WARM];
                  default: ;
               endcase
            end
            twdc_pkg::ACT_SET_ON:    on_in    = |req_value;
            twdc_pkg::ACT_SET_LEVEL: level_in = bound(sat_value, lvl_min_ff, lvl_max_ff);
            twdc_pkg::ACT_SET_MIX:   mix_in   = sat_value;
            twdc_pkg::ACT_TOGGLE:    on_in    = ~on_ff;
            default: ;
         endcase
      end
   end

   // mode decode and bounded brightness
   assign is_single = (mode_ff == twdc_pkg::MODE_SINGLE);
   assign is_dual   = (mode_ff == twdc_pkg::MODE_DUAL);
   assign status.composite = on_ff && !is_single && !is_dual;
   assign b_now = bound(level_ff, lvl_min_ff, lvl_max_ff);
   assign m_now = (17'(mix_ff) > 17'(DUTY_FULL)) ? 10'(DUTY_FULL) : mix_ff;

   // channel range selection
   assign rng    = cmd.warm ? warm_rng_ff : cold_rng_ff;
   assign rng_lo = rng[9:0];
   assign rng_hi = rng[19:10];
   assign span_v = cmd.warm ? vw_ff : vc_ff;

   // shared multiplier
   always_comb begin
      if (cmd.prep) begin
         mul_a = b_now;
         mul_b = m_now;
      end else begin
         mul_a = span_v;
         mul_b = rng_hi - rng_lo;
      end
   end
   assign mul_p = 20'(mul_a) * 20'(mul_b);

   // divide by full scale through the reciprocal
   assign div_p = PW'(prod_ff) * PW'(RECIP);
   assign div_q = div_p[SHIFT +: QW];

   // range mapping of a channel value
   assign span_sum = SW'(rng_lo) + SW'(div_q);
   always_comb begin
      if (span_v == 10'd0) begin
         span_res = 10'd0;
      end else if (rng_hi <= rng_lo) begin
         span_res = rng_lo;
      end else if (span_sum > SW'(rng_hi)) begin
         span_res = rng_hi;
      end else begin
         span_res = 10'(span_sum);
      end
   end

   // working registers per step
   always_comb begin
      b_in    = b_ff;
      vc_in   = vc_ff;
      vw_in   = vw_ff;
      prod_in = prod_ff;
      cold_in = cold_ff;
      warm_in = warm_ff;
      if (cmd.prep) begin
         b_in    = b_now;
         prod_in = DIVW'(mul_p);
         vc_in   = 10'd0;
         vw_in   = 10'd0;
         if (on_ff && is_single) begin
            vc_in = b_now;
         end else if (on_ff && is_dual) begin
            vc_in = bound(cold_lvl_ff, lvl_min_ff, lvl_max_ff);
            vw_in = bound(warm_lvl_ff, lvl_min_ff, lvl_max_ff);
         end
      end
      if (cmd.mix_cold) begin
         // floor for cold, then bias the product so the warm share, b less the rounded-up quotient, is floored
         vc_in   = 10'(div_q);
         prod_in = prod_ff + DIVW'(DUTY_FULL - 1);
      end
      if (cmd.mix_warm) begin
         vw_in = b_ff - 10'(div_q);
      end
      if (cmd.span_mul) begin
         prod_in = DIVW'(mul_p);
      end
      if (cmd.span_div) begin
         if (cmd.warm) begin
            warm_in = span_res;
         end else begin
            cold_in = span_res;
         end
      end
   end

   // output register
   always_comb begin
      out_cold_in  = out_cold_ff;
      out_warm_in  = out_warm_ff;
      out_on_in    = out_on_ff;
      out_level_in = out_level_ff;
      out_mix_in   = out_mix_ff;
      if (cmd.load_out) begin
         out_cold_in  = cold_ff;
         out_warm_in  = warm_ff;
         out_on_in    = on_ff;
         out_level_in = level_ff;
         out_mix_in   = mix_ff;
      end
   end

   // configuration and dimmer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= twdc_pkg::MODE_MIX;
         lvl_min_ff  <= 10'd0;
         lvl_max_ff  <= 10'd1023;
         cold_rng_ff <= {10'd1023, 10'd0};
         warm_rng_ff <= {10'd1023, 10'd0};
         lvl_step_ff <= 10'd16;
         mix_step_ff <= 10'd16;
         btn_map_ff  <= 12'd26;
         on_ff       <= 1'b1;
         level_ff    <= 10'd512;
         mix_ff      <= 10'd512;
         cold_lvl_ff <= 10'd512;
         warm_lvl_ff <= 10'd512;
         dir_ff      <= 4'b1111;
      end else begin
         mode_ff     <= mode_in;
         lvl_min_ff  <= lvl_min_in;
         lvl_max_ff  <= lvl_max_in;
         cold_rng_ff <= cold_rng_in;
         warm_rng_ff <= warm_rng_in;
         lvl_step_ff <= lvl_step_in;
         mix_step_ff <= mix_step_in;
         btn_map_ff  <= btn_map_in;
         on_ff       <= on_in;
         level_ff    <= level_in;
         mix_ff      <= mix_in;
         cold_lvl_ff <= cold_lvl_in;
         warm_lvl_ff <= warm_lvl_in;
         dir_ff      <= dir_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      b_ff         <= b_in;
      vc_ff        <= vc_in;
      vw_ff        <= vw_in;
      prod_ff      <= prod_in;
      cold_ff      <= cold_in;
      warm_ff      <= warm_in;
      out_cold_ff  <= out_cold_in;
      out_warm_ff  <= out_warm_in;
      out_on_ff    <= out_on_in;
      out_level_ff <= out_level_in;
      out_mix_ff   <= out_mix_in;
   end

   assign rsp_cold_duty = out_cold_ff;
   assign rsp_warm_duty = out_warm_ff;
   assign rsp_is_on     = out_on_ff;
   assign rsp_level_now = out_level_ff;
   assign rsp_mix_now   = out_mix_ff;

endmodule

@@ rtl/tunable_white_dimmer_control.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// req_      in         req_valid/req_ready   action, button, value
// rsp_      out        rsp_valid/rsp_ready   cold_duty, warm_duty, is_on, level_now, mix_now
// csr_      in         csr_valid/csr_ready   index, data (always ready)
//
// an item steps from accept through prep, cold multiply, cold divide, warm multiply, warm divide
// and result load, with mix cold and mix warm steps after prep in colour mix mode while enabled;
// the next item is accepted in the cycle after the load; the steps follow from the one shared
// multiplier and the reciprocal divide, one use per step; reset is synchronous and puts the
// configuration, sequencer and dimmer state at their defaults; a finished result waits in the
// output register, the next item is accepted meanwhile and its last step holds until that register is free

`include "tunable_white_dimmer_control_defines.svh"

module tunable_white_dimmer_control #(
   parameter int DUTY_FULL = 1023
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [1:0]  req_button,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_cold_duty,
   output logic [9:0]  rsp_warm_duty,
   output logic        rsp_is_on,
   output logic [9:0]  rsp_level_now,
   output logic [9:0]  rsp_mix_now,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [19:0] csr_data
);

   twdc_pkg::cmd_type    cmd;
   twdc_pkg::status_type status;
   logic                 csr_we;

   // registers are writable at any time
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   // sequencer
   twdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // state, arithmetic and output register
   twdc_datapath #(
      .DUTY_FULL (DUTY_FULL)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_action    (req_action),
      .req_button    (req_button),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_cold_duty (rsp_cold_duty),
      .rsp_warm_duty (rsp_warm_duty),
      .rsp_is_on     (rsp_is_on),
      .rsp_level_now (rsp_level_now),
      .rsp_mix_now   (rsp_mix_now)
   );

   // one item in work at a time
   `TWDC_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "second item accepted during work")
   // a result is never loaded over one still waiting
   `TWDC_ASSERT_SAME(a_slot_free, clock, reset, cmd.load_out, !rsp_valid || rsp_ready, "result loaded over waiting item")
   // a result appears only after a load
   `TWDC_ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_valid), $past(cmd.load_out), "result shown without a load")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int          HALF_PERIOD   = 5;
   localparam int          RESET_CYCLES  = 11;
   localparam int          CYCLE_LIMIT   = 600000;
   localparam int          SETTLE_CYCLES = 24;
   localparam int          REPORT_LIMIT  = 10;
   localparam int unsigned DUTY_FULL     = 1023;
   localparam int unsigned LEVEL_TOP     = 1023;
   localparam int unsigned MASK10        = 32'h3FF;

   // codes the package leaves unnamed
   localparam logic [2:0] ACT_SPARE    = 3'd7;
   localparam logic [2:0] KIND_SPARE_A = 3'd6;
   localparam logic [2:0] KIND_SPARE_B = 3'd7;
   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam logic [3:0] CSR_UNUSED   = 4'd12;

   // common range settings
   localparam logic [19:0] RANGE_FULL = 20'hFFC00;
   localparam logic [19:0] RANGE_NONE = 20'h00000;

   typedef struct {
      logic [9:0] cold;
      logic [9:0] warm;
      logic       is_on;
      logic [9:0] level;
      logic [9:0] mix;
   } duty_result_type;

   typedef enum {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_HOLD} stall_style_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_action;
   logic [1:0]  req_button;
   logic [15:0] req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [9:0]  rsp_cold_duty;
   logic [9:0]  rsp_warm_duty;
   logic        rsp_is_on;
   logic [9:0]  rsp_level_now;
   logic [9:0]  rsp_mix_now;
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_index;
   logic [19:0] csr_data;

   // shadow registers
   int unsigned cfg_mode, cfg_lmin, cfg_lmax, cfg_cold_range, cfg_warm_range;
   int unsigned cfg_lstep, cfg_mstep, cfg_map;

   // predicted dimmer state
   bit          dim_on;
   int unsigned dim_level, dim_mix, dim_cold, dim_warm;
   bit [3:0]    dir_up;

   duty_result_type pending_results[$];

   int cycle_count   = 0;
   int fault_count   = 0;
   int results_seen  = 0;
   int items_sent    = 0;
   int reg_writes    = 0;
   int setting_count = 0;
   int burst_left    = 0;
   int stall_left    = 0;
   stall_style_type stall_style = STALL_NONE;

   tunable_white_dimmer_control #(
      .DUTY_FULL(DUTY_FULL)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_button(req_button),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cold_duty(rsp_cold_duty),
      .rsp_warm_duty(rsp_warm_duty),
      .rsp_is_on(rsp_is_on),
      .rsp_level_now(rsp_level_now),
      .rsp_mix_now(rsp_mix_now),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void reset_dimmer();
      cfg_mode       = 32'(twdc_pkg::MODE_MIX);
      cfg_lmin       = 0;
      cfg_lmax       = 1023;
      cfg_cold_range = 32'(RANGE_FULL);
      cfg_warm_range = 32'(RANGE_FULL);
      cfg_lstep      = 16;
      cfg_mstep      = 16;
      cfg_map        = 26;
      dim_on         = 1'b1;
      dim_level      = 512;
      dim_mix        = 512;
      dim_cold       = 512;
      dim_warm       = 512;
      dir_up         = 4'b1111;
   endfunction

   function automatic void record_reg(logic [3:0] index, logic [19:0] data);
      case (index)
         twdc_pkg::CSR_MODE:       cfg_mode       = 32'(data) & 32'h3;
         twdc_pkg::CSR_LEVEL_MIN:  cfg_lmin       = 32'(data) & MASK10;
         twdc_pkg::CSR_LEVEL_MAX:  cfg_lmax       = 32'(data) & MASK10;
         twdc_pkg::CSR_COLD_RANGE: cfg_cold_range = 32'(data);
         twdc_pkg::CSR_WARM_RANGE: cfg_warm_range = 32'(data);
         twdc_pkg::CSR_LEVEL_STEP: cfg_lstep      = 32'(data) & MASK10;
         twdc_pkg::CSR_MIX_STEP:   cfg_mstep      = 32'(data) & MASK10;
         twdc_pkg::CSR_BUTTON_MAP: cfg_map        = 32'(data) & 32'hFFF;
         default: ;
      endcase
   endfunction

   function automatic int unsigned clamp_window(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // map a brightness onto a duty min..max window
   function automatic int unsigned scale_duty(int unsigned v, int unsigned range);
      int unsigned lo, hi, r;
      lo = range & MASK10;
      hi = (range >> 10) & MASK10;
      if (v == 0) return 0;
      if (hi <= lo) return lo;
      r = lo + (v * (hi - lo)) / DUTY_FULL;
      return (r > hi) ? hi : r;
   endfunction

   function automatic int unsigned step_level(int unsigned v, bit up);
      int unsigned s;
      if (up) begin
         s = (cfg_lstep < cfg_lmax) ? cfg_lstep : cfg_lmax;
         return (v >= cfg_lmax - s) ? cfg_lmax : v + cfg_lstep;
      end
      return (v <= cfg_lmin + cfg_lstep) ? cfg_lmin : v - cfg_lstep;
   endfunction

   function automatic int unsigned step_mix(int unsigned v, bit up);
      if (up)
         return (cfg_mstep >= LEVEL_TOP || v >= LEVEL_TOP - cfg_mstep) ? LEVEL_TOP : v + cfg_mstep;
      return (v <= cfg_mstep) ? 0 : v - cfg_mstep;
   endfunction

   // spare map codes act as no mapping
   function automatic twdc_pkg::kind_type button_kind(logic [1:0] button);
      int unsigned k;
      if (32'(button) >= twdc_pkg::BUTTONS) return twdc_pkg::KIND_NONE;
      k = (cfg_map >> (3 * 32'(button))) & 32'h7;
      return (k > 32'(twdc_pkg::KIND_WARM)) ? twdc_pkg::KIND_NONE : twdc_pkg::kind_type'(k);
   endfunction

   // update the dimmer state for one item and give its duties
   function automatic duty_result_type apply_event(logic [2:0] action, logic [1:0] button,
                                                   logic [15:0] value);
      twdc_pkg::kind_type kind;
      int unsigned        val, b, m;
      duty_result_type    res;
      kind = button_kind(button);
      val  = 32'(value);
      case (action)
         twdc_pkg::ACT_CLICK: begin
            if (kind == twdc_pkg::KIND_TOGGLE || kind == twdc_pkg::KIND_LEVEL) begin
               dim_on = !dim_on;
            end else if (kind == twdc_pkg::KIND_MIX) begin
               dim_on = 1'b1;
               if (dim_mix < 32'(twdc_pkg::MIX_LOW_EDGE)) dim_mix = 32'(twdc_pkg::MIX_PRESET);
               else if (dim_mix < 32'(twdc_pkg::MIX_HIGH_EDGE)) dim_mix = LEVEL_TOP;
               else dim_mix = 0;
            end
         end
         twdc_pkg::ACT_HOLD: begin
            case (kind)
               twdc_pkg::KIND_LEVEL: begin
                  dim_on = 1'b1;
                  dim_level = step_level(dim_level, dir_up[0]);
               end
               twdc_pkg::KIND_MIX: begin
                  dim_on = 1'b1;
                  dim_mix = step_mix(dim_mix, dir_up[1]);
               end
               twdc_pkg::KIND_COLD: begin
                  dim_on = 1'b1;
                  dim_cold = step_level(dim_cold, dir_up[2]);
               end
               twdc_pkg::KIND_WARM: begin
                  dim_on = 1'b1;
                  dim_warm = step_level(dim_warm, dir_up[3]);
               end
               default: ;
            endcase
         end
         twdc_pkg::ACT_RELEASE: begin
            case (kind)
               twdc_pkg::KIND_LEVEL: dir_up[0] = !dir_up[0];
               twdc_pkg::KIND_MIX:   dir_up[1] = !dir_up[1];
               twdc_pkg::KIND_COLD:  dir_up[2] = !dir_up[2];
               twdc_pkg::KIND_WARM:  dir_up[3] = !dir_up[3];
               default: ;
            endcase
         end
         twdc_pkg::ACT_SET_ON:    dim_on = (val != 0);
         twdc_pkg::ACT_SET_LEVEL: dim_level = clamp_window((val > LEVEL_TOP) ? LEVEL_TOP : val,
                                                           cfg_lmin, cfg_lmax);
         twdc_pkg::ACT_SET_MIX:   dim_mix = (val > LEVEL_TOP) ? LEVEL_TOP : val;
         twdc_pkg::ACT_TOGGLE:    dim_on = !dim_on;
         default: ;
      endcase
      dim_level &= MASK10;
      dim_mix   &= MASK10;
      dim_cold  &= MASK10;
      dim_warm  &= MASK10;

      res.cold = '0;
      res.warm = '0;
      if (dim_on) begin
         b = clamp_window(dim_level, cfg_lmin, cfg_lmax);
         if (cfg_mode == 32'(twdc_pkg::MODE_SINGLE)) begin
            res.cold = 10'(scale_duty(b, cfg_cold_range));
         end else if (cfg_mode == 32'(twdc_pkg::MODE_DUAL)) begin
            res.cold = 10'(scale_duty(clamp_window(dim_cold, cfg_lmin, cfg_lmax),
                                      cfg_cold_range));
            res.warm = 10'(scale_duty(clamp_window(dim_warm, cfg_lmin, cfg_lmax),
                                      cfg_warm_range));
         end else begin
            m = (dim_mix > DUTY_FULL) ? DUTY_FULL : dim_mix;
            res.cold = 10'(scale_duty((b * m) / DUTY_FULL, cfg_cold_range));
            res.warm = 10'(scale_duty((b * (DUTY_FULL - m)) / DUTY_FULL, cfg_warm_range));
         end
      end
      res.is_on = dim_on;
      res.level = 10'(dim_level);
      res.mix   = 10'(dim_mix);
      return res;
   endfunction

   // ---------------------------------------------------------------- drivers

   // one item on the request channel, with a random gap between bursts
   task automatic send_item(logic [2:0] action, logic [1:0] button, logic [15:0] value);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 14);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= action;
      req_button <= button;
      req_value  <= value;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_event(action, button, value));
      items_sent++;
   endtask

   task automatic write_reg(logic [3:0] index, logic [19:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      record_reg(index, data);
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(logic [1:0] mode, logic [9:0] lmin, logic [9:0] lmax,
                                 logic [19:0] cold_range, logic [19:0] warm_range,
                                 logic [9:0] lstep, logic [9:0] mstep, logic [11:0] map);
      wait_drained();
      write_reg(twdc_pkg::CSR_MODE, 20'(mode));
      write_reg(twdc_pkg::CSR_LEVEL_MIN, 20'(lmin));
      write_reg(twdc_pkg::CSR_LEVEL_MAX, 20'(lmax));
      write_reg(twdc_pkg::CSR_COLD_RANGE, cold_range);
      write_reg(twdc_pkg::CSR_WARM_RANGE, warm_range);
      write_reg(twdc_pkg::CSR_LEVEL_STEP, 20'(lstep));
      write_reg(twdc_pkg::CSR_MIX_STEP, 20'(mstep));
      write_reg(twdc_pkg::CSR_BUTTON_MAP, 20'(map));
      setting_count++;
   endtask

   function automatic logic [11:0] make_map(logic [2:0] k0, logic [2:0] k1,
                                            logic [2:0] k2, logic [2:0] k3);
      return {k3, k2, k1, k0};
   endfunction

   function automatic logic [9:0] pick_level();
      case ($urandom_range(0, 4))
         0: return 10'd0;
         1: return 10'd1023;
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic logic [9:0] pick_step();
      case ($urandom_range(0, 7))
         0: return 10'd0;
         1: return 10'd1;
         2: return 10'd1023;
         3: return 10'($urandom_range(0, 1023));
         default: return 10'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [19:0] pick_range();
      case ($urandom_range(0, 4))
         0: return RANGE_FULL;
         1: return RANGE_NONE;
         default: return 20'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'd1023;
         3: return 16'd1024;
         4: return 16'($urandom_range(0, 1023));
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly whole gestures: click, or a run of hold repeats closed by a release
   task automatic random_gesture();
      logic [1:0] button;
      logic [2:0] act;
      int         pick, holds;
      button = 2'($urandom_range(0, 3));
      pick   = $urandom_range(0, 99);
      if (pick < 25) begin
         send_item(twdc_pkg::ACT_CLICK, button, 16'($urandom));
      end else if (pick < 65) begin
         holds = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
         repeat (holds) send_item(twdc_pkg::ACT_HOLD, button, 16'($urandom));
         send_item(twdc_pkg::ACT_RELEASE, button, 16'($urandom));
      end else if (pick < 88) begin
         case ($urandom_range(0, 3))
            0: act = twdc_pkg::ACT_SET_ON;
            1: act = twdc_pkg::ACT_SET_LEVEL;
            2: act = twdc_pkg::ACT_SET_MIX;
            default: act = twdc_pkg::ACT_TOGGLE;
         endcase
         send_item(act, button, pick_value());
      end else if (pick < 95) begin
         send_item(3'($urandom_range(0, 7)), button, 16'($urandom));
      end else begin
         send_item(ACT_SPARE, button, 16'($urandom));
      end
   endtask

   task automatic run_items(int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) random_gesture();
   endtask

   // ---------------------------------------------------------------- receiver and checker

   // result channel ready follows a stall pattern picked at random, held for a random run and then picked anew
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left  = $urandom_range(4, 48);
      end
      stall_left--;
      case (stall_style)
         STALL_NONE:   rsp_ready <= 1'b1;
         STALL_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         STALL_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= 1'b0;
      endcase
   end

   // compare each result with the oldest predicted one
   always @(posedge clock) begin : check_results
      duty_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected result: cold %0d warm %0d on %0b level %0d mix %0d",
                        rsp_cold_duty, rsp_warm_duty, rsp_is_on, rsp_level_now, rsp_mix_now);
         end else begin
            want = pending_results.pop_front();
            results_seen++;
            if (rsp_cold_duty !== want.cold || rsp_warm_duty !== want.warm ||
                rsp_is_on !== want.is_on || rsp_level_now !== want.level ||
                rsp_mix_now !== want.mix) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display({"mismatch on result %0d (expected/actual): cold %0d/%0d ",
                            "warm %0d/%0d on %0b/%0b level %0d/%0d mix %0d/%0d"},
                           results_seen, want.cold, rsp_cold_duty, want.warm, rsp_warm_duty,
                           want.is_on, rsp_is_on, want.level, rsp_level_now,
                           want.mix, rsp_mix_now);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // defaults after reset: button 0 on brightness, button 1 on mix
   task automatic test_reset_state();
      send_item(twdc_pkg::ACT_HOLD, 2'd0, 16'h0000);
      send_item(twdc_pkg::ACT_CLICK, 2'd1, 16'hFFFF);
      send_item(twdc_pkg::ACT_CLICK, 2'd0, 16'h0000);
   endtask

   // direct commands, with a brightness window to clamp into
   task automatic test_commands();
      write_settings(twdc_pkg::MODE_MIX, 10'd100, 10'd900, RANGE_FULL, RANGE_FULL,
                     10'd16, 10'd16, 12'd26);
      send_item(twdc_pkg::ACT_SET_ON, 2'd3, 16'h0000);
      send_item(twdc_pkg::ACT_SET_ON, 2'd0, 16'h8000);
      send_item(twdc_pkg::ACT_SET_LEVEL, 2'd0, 16'h0000);
      send_item(twdc_pkg::ACT_SET_LEVEL, 2'd1, 16'hFFFF);
      send_item(twdc_pkg::ACT_SET_MIX, 2'd2, 16'h0000);
      send_item(twdc_pkg::ACT_SET_MIX, 2'd0, 16'h0400);
      send_item(twdc_pkg::ACT_TOGGLE, 2'd0, 16'h0000);
      send_item(twdc_pkg::ACT_TOGGLE, 2'd1, 16'h0000);
      send_item(ACT_SPARE, 2'd3, 16'hFFFF);
   endtask

   // every button kind: preset cycling, saturating holds, direction flips
   task automatic test_gestures();
      write_settings(twdc_pkg::MODE_DUAL, 10'd0, 10'd1023, RANGE_FULL, {10'd900, 10'd50},
                     10'd300, 10'd400,
                     make_map(twdc_pkg::KIND_MIX, twdc_pkg::KIND_COLD, twdc_pkg::KIND_WARM,
                              twdc_pkg::KIND_TOGGLE));
      repeat (3) send_item(twdc_pkg::ACT_CLICK, 2'd0, 16'h0000);
      repeat (3) send_item(twdc_pkg::ACT_HOLD, 2'd1, 16'h0000);
      send_item(twdc_pkg::ACT_RELEASE, 2'd1, 16'h0000);
      send_item(twdc_pkg::ACT_HOLD, 2'd1, 16'h0000);
      send_item(twdc_pkg::ACT_RELEASE, 2'd2, 16'h0000);
      send_item(twdc_pkg::ACT_HOLD, 2'd2, 16'h0000);
      send_item(twdc_pkg::ACT_HOLD, 2'd0, 16'h0000);
      send_item(twdc_pkg::ACT_CLICK, 2'd3, 16'h0000);
      send_item(twdc_pkg::ACT_HOLD, 2'd3, 16'h0000);
      // spare map codes and an empty slot do nothing
      write_settings(twdc_pkg::MODE_SINGLE, 10'd0, 10'd1023, RANGE_FULL, RANGE_FULL,
                     10'd16, 10'd16,
                     make_map(twdc_pkg::KIND_LEVEL, KIND_SPARE_A, KIND_SPARE_B,
                              twdc_pkg::KIND_NONE));
      send_item(twdc_pkg::ACT_HOLD, 2'd1, 16'h0000);
      send_item(twdc_pkg::ACT_CLICK, 2'd2, 16'h0000);
      send_item(twdc_pkg::ACT_RELEASE, 2'd3, 16'h0000);
   endtask

   // register extremes: full and empty windows, zero and top steps, spare mode
   task automatic test_setting_extremes();
      write_settings(twdc_pkg::MODE_SINGLE, 10'd0, 10'd1023, RANGE_FULL, RANGE_FULL,
                     10'd1, 10'd1,
                     make_map(twdc_pkg::KIND_LEVEL, twdc_pkg::KIND_MIX, twdc_pkg::KIND_COLD,
                              twdc_pkg::KIND_WARM));
      run_items(70);
      write_settings(twdc_pkg::MODE_DUAL, 10'd0, 10'd0, RANGE_NONE, RANGE_NONE, 10'd0, 10'd0,
                     make_map(twdc_pkg::KIND_COLD, twdc_pkg::KIND_WARM, twdc_pkg::KIND_LEVEL,
                              twdc_pkg::KIND_MIX));
      run_items(70);
      write_settings(twdc_pkg::MODE_MIX, 10'd1023, 10'd1023, 20'hFFFFF, 20'h003FF,
                     10'd1023, 10'd1023,
                     make_map(twdc_pkg::KIND_MIX, twdc_pkg::KIND_LEVEL, twdc_pkg::KIND_TOGGLE,
                              KIND_SPARE_B));
      run_items(70);
      write_settings(MODE_SPARE, 10'd100, 10'd900, {10'd800, 10'd200}, {10'd1023, 10'd0},
                     10'd1023, 10'd1022,
                     make_map(twdc_pkg::KIND_WARM, twdc_pkg::KIND_COLD, twdc_pkg::KIND_MIX,
                              twdc_pkg::KIND_LEVEL));
      run_items(70);
      // a write to an index with no register behind it changes nothing
      wait_drained();
      write_reg(CSR_UNUSED, 20'hFFFFF);
      run_items(40);
   endtask

   task automatic test_random_settings();
      logic [9:0] lo, hi, t;
      repeat (15) begin
         lo = pick_level();
         hi = pick_level();
         if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
         end
         write_settings(2'($urandom_range(0, 3)), lo, hi, pick_range(), pick_range(),
                        pick_step(), pick_step(), 12'($urandom));
         run_items(70);
      end
   endtask

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_action = '0;
      req_button = '0;
      req_value  = '0;
      rsp_ready  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      reset_dimmer();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_commands();
      test_gestures();
      test_setting_extremes();
      test_random_settings();

      wait_drained();
      $display("%0d items sent and %0d results checked over %0d register settings (%0d writes)",
               items_sent, results_seen, setting_count, reg_writes);
      $display("all actions, button kinds and duty modes exercised, %0d faults", fault_count);
      if (fault_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ tunable_white_dimmer_control.f @@
+incdir+rtl
rtl/twdc_pkg.sv
rtl/twdc_ctrl.sv
rtl/twdc_datapath.sv
rtl/tunable_white_dimmer_control.sv
tb/testbench.sv
